/* rtl/aff_pkg.sv */
// Package: shared widths, limits, lane codes, pipeline word types and the clamp function.
package aff_pkg;

	localparam int WORD_W    = 32;
	localparam int DET_W     = 64;
	localparam int LANES     = 4;
	localparam int DIV_STEPS = 32;

	localparam logic [DET_W-1:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;
	localparam logic [DET_W-1:0] NEG_LIM = 64'h0000_0000_8000_0000;

	localparam int LANE_A = 0;
	localparam int LANE_B = 1;
	localparam int LANE_C = 2;
	localparam int LANE_D = 3;

	typedef struct packed {
		logic [DET_W-1:0]  rem;
		logic [WORD_W-1:0] quo;
		logic              ovf;
		logic              neg;
	} lane_t;

	typedef struct packed {
		lane_t [LANES-1:0]        lane;
		logic [DET_W-1:0]         dmag;
		logic signed [WORD_W-1:0] move_x;
		logic signed [WORD_W-1:0] move_y;
		logic                     singular;
	} div_word_t;

	typedef struct packed {
		logic [WORD_W-1:0] coef;
		logic              sat;
	} clamp_t;

	function automatic clamp_t clamp64(input logic neg, input logic big,
			input logic [DET_W-1:0] mag);
		logic [DET_W-1:0] lim;
		logic [DET_W-1:0] m;
		clamp_t           res;
		lim     = neg ? NEG_LIM : POS_LIM;
		res.sat = big || (mag > lim);
		m       = res.sat ? lim : mag;
		res.coef = neg ? WORD_W'(-m) : m[WORD_W-1:0];
		return res;
	endfunction

endpackage

/* rtl/aff_in_if.sv */
// Interface: input channel carrying one matrix word.
interface aff_in_if;
	logic                           valid;
	logic                           ready;
	logic signed [aff_pkg::WORD_W-1:0] scale_x;
	logic signed [aff_pkg::WORD_W-1:0] shear_y;
	logic signed [aff_pkg::WORD_W-1:0] shear_x;
	logic signed [aff_pkg::WORD_W-1:0] scale_y;
	logic signed [aff_pkg::WORD_W-1:0] move_x;
	logic signed [aff_pkg::WORD_W-1:0] move_y;

	modport source (output valid, scale_x, shear_y, shear_x, scale_y, move_x, move_y,
		input ready);
	modport sink (input valid, scale_x, shear_y, shear_x, scale_y, move_x, move_y,
		output ready);
endinterface

/* rtl/aff_out_if.sv */
// Interface: output channel carrying one inverse matrix word.
interface aff_out_if;
	logic                           valid;
	logic                           ready;
	logic signed [aff_pkg::WORD_W-1:0] inv_scale_x;
	logic signed [aff_pkg::WORD_W-1:0] inv_shear_y;
	logic signed [aff_pkg::WORD_W-1:0] inv_shear_x;
	logic signed [aff_pkg::WORD_W-1:0] inv_scale_y;
	logic signed [aff_pkg::WORD_W-1:0] inv_move_x;
	logic signed [aff_pkg::WORD_W-1:0] inv_move_y;
	logic                           singular;
	logic                           saturated;

	modport source (output valid, inv_scale_x, inv_shear_y, inv_shear_x, inv_scale_y,
		inv_move_x, inv_move_y, singular, saturated, input ready);
	modport sink (input valid, inv_scale_x, inv_shear_y, inv_shear_x, inv_scale_y,
		inv_move_x, inv_move_y, singular, saturated, output ready);
endinterface

/* rtl/affine_2x3_matrix_inverter.sv */
// Top level: inverse of a 2D affine matrix in signed fixed point, fully pipelined.
//
//  channel   modport  word
//  mat_in    sink     scale_x shear_y shear_x scale_y move_x move_y
//  inv_out   source   inv_scale_x inv_shear_y inv_shear_x inv_scale_y
//                     inv_move_x inv_move_y singular saturated
//
// One word in per cycle, one word out per cycle while inv_out.ready holds; the stages are:
// 3 front stages, 32 divider stages (one quotient bit each), 4 back stages.
// Reset clears every stage valid bit; payload registers are not reset.
// Each stage holds while the stage after it is full and stalled; bubbles close up.
module affine_2x3_matrix_inverter #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	aff_in_if.sink     mat_in,
	aff_out_if.source  inv_out
);
	logic               dv  [aff_pkg::DIV_STEPS+1];
	logic               dr  [aff_pkg::DIV_STEPS+1];
	aff_pkg::div_word_t dd  [aff_pkg::DIV_STEPS+1];

	aff_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.mat_in    (mat_in),
		.out_valid (dv[0]),
		.out_ready (dr[0]),
		.out_data  (dd[0])
	);

	for (genvar k = 0; k < aff_pkg::DIV_STEPS; k++) begin : g_div
		aff_div_stage u_step (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (dv[k]),
			.in_ready  (dr[k]),
			.in_data   (dd[k]),
			.out_valid (dv[k+1]),
			.out_ready (dr[k+1]),
			.out_data  (dd[k+1])
		);
	end

	aff_back #(.FRAC_BITS(FRAC_BITS)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dv[aff_pkg::DIV_STEPS]),
		.in_ready (dr[aff_pkg::DIV_STEPS]),
		.in_data  (dd[aff_pkg::DIV_STEPS]),
		.inv_out  (inv_out)
	);

	a_singular_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inv_out.valid && inv_out.singular |-> inv_out.inv_scale_x == '0
			&& inv_out.inv_shear_y == '0 && inv_out.inv_shear_x == '0
			&& inv_out.inv_scale_y == '0 && inv_out.inv_move_x == '0
			&& inv_out.inv_move_y == '0 && !inv_out.saturated)
		else $error("singular word with nonzero coefficients");

endmodule

/* rtl/aff_front.sv */
// Front pipeline: determinant products, determinant magnitude, divider lane set-up.
module aff_front #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	aff_in_if.sink             mat_in,
	output logic               out_valid,
	input  logic               out_ready,
	output aff_pkg::div_word_t out_data
);
	localparam int DW = aff_pkg::WORD_W + 2 * FRAC_BITS;

	logic v_s1, v_s2, v_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [aff_pkg::DET_W-1:0]  p03_s1, p12_s1;
	logic signed [aff_pkg::WORD_W-1:0] m0_s1, m1_s1, m2_s1, m3_s1, m4_s1, m5_s1;

	logic [aff_pkg::DET_W-1:0]         dmag_s2;
	logic                              dneg_s2;
	logic signed [aff_pkg::WORD_W-1:0] m0_s2, m1_s2, m2_s2, m3_s2, m4_s2, m5_s2;

	aff_pkg::div_word_t d_s3;

	logic [aff_pkg::DET_W-1:0] det;
	aff_pkg::div_word_t        nxt_s3;

	assign rdy_s3       = !v_s3 || out_ready;
	assign rdy_s2       = !v_s2 || rdy_s3;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign mat_in.ready = rdy_s1;
	assign out_valid    = v_s3;
	assign out_data     = d_s3;

	assign det = aff_pkg::DET_W'(p03_s1 - p12_s1);

	always_comb begin
		logic signed [aff_pkg::WORD_W-1:0] num [aff_pkg::LANES];
		logic                              nneg [aff_pkg::LANES];
		logic [aff_pkg::WORD_W-1:0]        nmag;
		logic [DW-1:0]                     dv;
		logic [aff_pkg::DET_W-1:0]         top;
		num[aff_pkg::LANE_A]  = m3_s2;
		num[aff_pkg::LANE_B]  = m1_s2;
		num[aff_pkg::LANE_C]  = m2_s2;
		num[aff_pkg::LANE_D]  = m0_s2;
		nneg[aff_pkg::LANE_A] = m3_s2[aff_pkg::WORD_W-1];
		nneg[aff_pkg::LANE_B] = !m1_s2[aff_pkg::WORD_W-1];
		nneg[aff_pkg::LANE_C] = !m2_s2[aff_pkg::WORD_W-1];
		nneg[aff_pkg::LANE_D] = m0_s2[aff_pkg::WORD_W-1];
		nxt_s3.dmag     = dmag_s2;
		nxt_s3.move_x   = m4_s2;
		nxt_s3.move_y   = m5_s2;
		nxt_s3.singular = (dmag_s2 == '0);
		for (int i = 0; i < aff_pkg::LANES; i++) begin
			nmag = num[i][aff_pkg::WORD_W-1] ? aff_pkg::WORD_W'(-num[i]) : num[i];
			dv   = {nmag, (2 * FRAC_BITS)'(0)};
			top  = aff_pkg::DET_W'(dv >> aff_pkg::WORD_W);
			nxt_s3.lane[i].ovf = (top >= dmag_s2);
			nxt_s3.lane[i].rem = nxt_s3.lane[i].ovf ? '0 : top;
			nxt_s3.lane[i].quo = dv[aff_pkg::WORD_W-1:0];
			nxt_s3.lane[i].neg = nneg[i] ^ dneg_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= mat_in.valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && mat_in.valid) begin
			p03_s1 <= mat_in.scale_x * mat_in.scale_y;
			p12_s1 <= mat_in.shear_y * mat_in.shear_x;
			m0_s1  <= mat_in.scale_x;
			m1_s1  <= mat_in.shear_y;
			m2_s1  <= mat_in.shear_x;
			m3_s1  <= mat_in.scale_y;
			m4_s1  <= mat_in.move_x;
			m5_s1  <= mat_in.move_y;
		end
		if (rdy_s2 && v_s1) begin
			dneg_s2 <= det[aff_pkg::DET_W-1];
			dmag_s2 <= det[aff_pkg::DET_W-1] ? -det : det;
			m0_s2   <= m0_s1;
			m1_s2   <= m1_s1;
			m2_s2   <= m2_s1;
			m3_s2   <= m3_s1;
			m4_s2   <= m4_s1;
			m5_s2   <= m5_s1;
		end
		if (rdy_s3 && v_s2) d_s3 <= nxt_s3;
	end

	a_init_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (d_s3.lane[0].ovf || d_s3.lane[0].rem < d_s3.dmag)
			&& (d_s3.lane[1].ovf || d_s3.lane[1].rem < d_s3.dmag)
			&& (d_s3.lane[2].ovf || d_s3.lane[2].rem < d_s3.dmag)
			&& (d_s3.lane[3].ovf || d_s3.lane[3].rem < d_s3.dmag))
		else $error("initial remainder not below divisor");

endmodule

/* rtl/aff_div_stage.sv */
// Divider stage: one restoring quotient bit for each of the four lanes.
module aff_div_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aff_pkg::div_word_t in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output aff_pkg::div_word_t out_data
);
	logic               v_s1;
	aff_pkg::div_word_t d_s1;
	aff_pkg::div_word_t nxt;

	assign in_ready  = !v_s1 || out_ready;
	assign out_valid = v_s1;
	assign out_data  = d_s1;

	always_comb begin
		logic [aff_pkg::DET_W:0] t;
		logic                    ge;
		nxt = in_data;
		for (int i = 0; i < aff_pkg::LANES; i++) begin
			t  = {in_data.lane[i].rem, in_data.lane[i].quo[aff_pkg::WORD_W-1]};
			ge = (t >= {1'b0, in_data.dmag});
			nxt.lane[i].rem = ge ? aff_pkg::DET_W'(t - {1'b0, in_data.dmag})
				: t[aff_pkg::DET_W-1:0];
			nxt.lane[i].quo = {in_data.lane[i].quo[aff_pkg::WORD_W-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) d_s1 <= nxt;
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (d_s1.lane[0].ovf || d_s1.lane[0].rem < d_s1.dmag)
			&& (d_s1.lane[1].ovf || d_s1.lane[1].rem < d_s1.dmag)
			&& (d_s1.lane[2].ovf || d_s1.lane[2].rem < d_s1.dmag)
			&& (d_s1.lane[3].ovf || d_s1.lane[3].rem < d_s1.dmag))
		else $error("partial remainder not below divisor");

endmodule

/* rtl/aff_back.sv */
// Back pipeline: coefficient clamp, translation products, sum and final clamp.
module aff_back #(
	parameter int unsigned FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  aff_pkg::div_word_t in_data,
	aff_out_if.source          inv_out
);
	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	logic [aff_pkg::WORD_W-1:0]        coef_s1 [aff_pkg::LANES];
	logic                              sat_s1, sing_s1;
	logic signed [aff_pkg::WORD_W-1:0] m4_s1, m5_s1;

	logic [aff_pkg::WORD_W-1:0]        coef_s2 [aff_pkg::LANES];
	logic                              sat_s2, sing_s2;
	logic signed [aff_pkg::DET_W-1:0]  pax_s2, pcy_s2, pbx_s2, pdy_s2;

	logic [aff_pkg::WORD_W-1:0]        coef_s3 [aff_pkg::LANES];
	logic                              sat_s3, sing_s3;
	logic [aff_pkg::DET_W-1:0]         ex_s3, ey_s3;

	aff_pkg::clamp_t cl [aff_pkg::LANES];
	aff_pkg::clamp_t clx, cly;

	assign rdy_s4   = !v_s4 || inv_out.ready;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_ready = rdy_s1;
	assign inv_out.valid = v_s4;

	always_comb begin
		for (int i = 0; i < aff_pkg::LANES; i++) begin
			cl[i] = aff_pkg::clamp64(
				in_data.lane[i].neg && (in_data.lane[i].ovf || in_data.lane[i].quo != '0),
				in_data.lane[i].ovf, aff_pkg::DET_W'(in_data.lane[i].quo));
		end
	end

	always_comb begin
		logic [aff_pkg::DET_W-1:0] mx, my;
		mx  = ex_s3[aff_pkg::DET_W-1] ? -ex_s3 : ex_s3;
		my  = ey_s3[aff_pkg::DET_W-1] ? -ey_s3 : ey_s3;
		mx  = mx >> FRAC_BITS;
		my  = my >> FRAC_BITS;
		clx = aff_pkg::clamp64(ex_s3[aff_pkg::DET_W-1] && mx != '0, 1'b0, mx);
		cly = aff_pkg::clamp64(ey_s3[aff_pkg::DET_W-1] && my != '0, 1'b0, my);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			for (int i = 0; i < aff_pkg::LANES; i++) coef_s1[i] <= cl[i].coef;
			sat_s1  <= cl[0].sat | cl[1].sat | cl[2].sat | cl[3].sat;
			sing_s1 <= in_data.singular;
			m4_s1   <= in_data.move_x;
			m5_s1   <= in_data.move_y;
		end
		if (rdy_s2 && v_s1) begin
			coef_s2 <= coef_s1;
			sat_s2  <= sat_s1;
			sing_s2 <= sing_s1;
			pax_s2  <= $signed(coef_s1[aff_pkg::LANE_A]) * m4_s1;
			pcy_s2  <= $signed(coef_s1[aff_pkg::LANE_C]) * m5_s1;
			pbx_s2  <= $signed(coef_s1[aff_pkg::LANE_B]) * m4_s1;
			pdy_s2  <= $signed(coef_s1[aff_pkg::LANE_D]) * m5_s1;
		end
		if (rdy_s3 && v_s2) begin
			coef_s3 <= coef_s2;
			sat_s3  <= sat_s2;
			sing_s3 <= sing_s2;
			ex_s3   <= aff_pkg::DET_W'(-(pax_s2 + pcy_s2));
			ey_s3   <= aff_pkg::DET_W'(-(pbx_s2 + pdy_s2));
		end
		if (rdy_s4 && v_s3) begin
			inv_out.inv_scale_x <= sing_s3 ? '0 : coef_s3[aff_pkg::LANE_A];
			inv_out.inv_shear_y <= sing_s3 ? '0 : coef_s3[aff_pkg::LANE_B];
			inv_out.inv_shear_x <= sing_s3 ? '0 : coef_s3[aff_pkg::LANE_C];
			inv_out.inv_scale_y <= sing_s3 ? '0 : coef_s3[aff_pkg::LANE_D];
			inv_out.inv_move_x  <= sing_s3 ? '0 : clx.coef;
			inv_out.inv_move_y  <= sing_s3 ? '0 : cly.coef;
			inv_out.singular    <= sing_s3;
			inv_out.saturated   <= !sing_s3 && (sat_s3 || clx.sat || cly.sat);
		end
	end

endmodule
